// File: src/pptt_pkg.sv
// shared types and constants for the pixel packet timestamp tracker
// no dependencies; imported by every module of the block
package pptt_pkg;

  localparam int WORD_W     = 64;
  localparam int TIME_W     = 48;
  localparam int HALF_W     = 32;
  localparam int EXT_W      = TIME_W - HALF_W;
  localparam int LAYOUT_W   = 8;
  localparam int COUNT_W    = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_GLOBAL_TIME = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMIT_HITS       = 1'd1;

  // result kinds
  localparam logic KIND_HIT    = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  // header signature bytes
  localparam logic [7:0] HDR_BYTE0 = 8'h54;  // 'T'
  localparam logic [7:0] HDR_BYTE1 = 8'h50;  // 'P'
  localparam logic [7:0] HDR_BYTE2 = 8'h58;  // 'X'

  // packet type codes in the top byte
  localparam logic [7:0] TOP_TRIGGER    = 8'h6F;
  localparam logic [3:0] NIB_GLOBAL     = 4'h4;
  localparam logic [3:0] NIB_HIT        = 4'hB;
  localparam logic [3:0] SUB_TIMER_LOW  = 4'h4;
  localparam logic [3:0] SUB_TIMER_HIGH = 4'h5;

  // local-mode rollover threshold
  localparam logic [HALF_W-1:0] ROLL_GAP = 32'h8000_0000;

  typedef struct packed {
    logic use_global_time;
    logic emit_hits;
  } cfg_t;

  typedef struct packed {
    logic                result_kind;
    logic [WORD_W-1:0]   raw_hit;
    logic [TIME_W-1:0]   trigger_time;
    logic [TIME_W-1:0]   global_time;
    logic [LAYOUT_W-1:0] chip_layout;
    logic [COUNT_W-1:0]  chunk_packets;
  } result_t;

endpackage

// File: src/pptt_cfg.sv
// configuration registers of the timestamp tracker
// depends on pptt_pkg
module pptt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pptt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pptt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pptt_pkg::cfg_t                   cfg
);
  import pptt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_global_time <= 1'b1;
      cfg.emit_hits       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USE_GLOBAL_TIME: cfg.use_global_time <= cfg_data[0];
        CFG_EMIT_HITS:       cfg.emit_hits       <= cfg_data[0];
      endcase
    end
  end

endmodule

// File: src/pptt_in_reg.sv
// input register stage: captures one detector word per accepted handshake
// depends on pptt_pkg
module pptt_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pptt_pkg::WORD_W-1:0] packet_word,
  input  logic                        advance,
  output logic                        word_valid,
  output logic [pptt_pkg::WORD_W-1:0] word
);
  import pptt_pkg::*;

  // hold while the processing stage cannot take the buffered word
  assign in_stall = word_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!in_stall) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word <= packet_word;
    end
  end

endmodule

// File: src/pptt_core.sv
// timestamp state, word classification and result register
// depends on pptt_pkg
module pptt_core (
  input  logic                        clk,
  input  logic                        rst,
  input  pptt_pkg::cfg_t              cfg,
  input  logic                        word_valid,
  input  logic [pptt_pkg::WORD_W-1:0] word,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pptt_pkg::result_t           result
);
  import pptt_pkg::*;

  logic [TIME_W-1:0]  trigger_clock, trigger_clock_next;
  logic [TIME_W-1:0]  global_clock, global_clock_next;
  logic [HALF_W-1:0]  timer_low_half, timer_low_half_next;
  logic [COUNT_W-1:0] packets_left, packets_left_next;

  logic              fire;
  logic              is_hdr, is_trig, is_glob, is_hit;
  logic [7:0]        top;
  logic [HALF_W-1:0] t, cur;
  logic [EXT_W-1:0]  hi_global, hi_local;
  logic              roll_local;
  logic [TIME_W-1:0] glob_val;
  logic              emit;
  result_t           res_next;

  assign advance = !out_valid || !out_stall;
  assign fire    = word_valid && advance;

  assign top     = word[63:56];
  assign is_hdr  = (word[7:0] == HDR_BYTE0) && (word[15:8] == HDR_BYTE1) &&
                   (word[23:16] == HDR_BYTE2);
  assign is_trig = (top == TOP_TRIGGER);
  assign is_glob = (top[7:4] == NIB_GLOBAL);
  assign is_hit  = (top[7:4] == NIB_HIT);

  // trigger extension
  assign t          = word[43:12];
  assign cur        = trigger_clock[HALF_W-1:0];
  assign hi_global  = global_clock[TIME_W-1:HALF_W] +
                      {{(EXT_W-1){1'b0}}, (t < global_clock[HALF_W-1:0])};
  assign roll_local = (t < cur) && ((cur - t) > ROLL_GAP);
  assign hi_local   = trigger_clock[TIME_W-1:HALF_W] + {{(EXT_W-1){1'b0}}, roll_local};

  // global time from the high half packet and the stored low half
  assign glob_val = {word[31:16], timer_low_half};

  always_comb begin
    trigger_clock_next  = trigger_clock;
    global_clock_next   = global_clock;
    timer_low_half_next = timer_low_half;
    packets_left_next   = packets_left;
    emit                = 1'b0;

    res_next.result_kind   = KIND_HIT;
    res_next.raw_hit       = word;
    res_next.trigger_time  = trigger_clock;
    res_next.global_time   = cfg.use_global_time ? global_clock : '0;
    res_next.chip_layout   = '0;
    res_next.chunk_packets = '0;

    if (is_hdr) begin
      packets_left_next      = word[63:51];
      emit                   = 1'b1;
      res_next.result_kind   = KIND_HEADER;
      res_next.raw_hit       = '0;
      res_next.chip_layout   = word[39:32];
      res_next.chunk_packets = word[63:51];
    end else if (packets_left != '0) begin
      packets_left_next = packets_left - 1'b1;
      if (is_trig) begin
        trigger_clock_next = {(cfg.use_global_time ? hi_global : hi_local), t};
      end else if (is_glob) begin
        if (cfg.use_global_time) begin
          if (top[3:0] == SUB_TIMER_LOW) begin
            timer_low_half_next = word[47:16];
          end else if (top[3:0] == SUB_TIMER_HIGH && glob_val != '0) begin
            global_clock_next = glob_val;
          end
        end
      end else if (is_hit) begin
        emit = cfg.emit_hits && (trigger_clock != '0) &&
               (!cfg.use_global_time || global_clock != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_clock  <= '0;
      global_clock   <= '0;
      timer_low_half <= '0;
      packets_left   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        trigger_clock  <= trigger_clock_next;
        global_clock   <= global_clock_next;
        timer_low_half <= timer_low_half_next;
        packets_left   <= packets_left_next;
      end
      if (advance) begin
        out_valid <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= res_next;
    end
  end

  // a hit result only goes out once a trigger time is known
  a_hit_has_trigger: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.result_kind == KIND_HIT) |-> (result.trigger_time != '0))
    else $error("hit result with zero trigger time");

  // global time once set never returns to zero outside reset
  a_global_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(global_clock) != '0) |-> (global_clock != '0))
    else $error("global clock cleared");

  // a non-header word only ever counts the chunk down
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_hdr && packets_left != '0) |=> (packets_left == $past(packets_left) - 1'b1))
    else $error("packet count not decremented");

  // without an open chunk a plain word changes no timestamp
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_hdr && packets_left == '0) |=>
      ($stable(trigger_clock) && $stable(global_clock) && $stable(timer_low_half)))
    else $error("state changed outside a chunk");

endmodule

// File: src/pixel_packet_timestamp_tracker_unit.sv
// top level of the pixel packet timestamp tracker
// depends on pptt_pkg, pptt_cfg, pptt_in_reg, pptt_core
//
// Takes 64-bit detector words and keeps the trigger and global timestamps of
// the readout stream. A word whose low three bytes spell the chunk signature
// opens a chunk of (size >> 3) packets and gives a header word with the
// layout byte; inside a chunk, trigger packets extend the 32-bit trigger time
// to 48 bits, global packets build the 48-bit global time, and hit packets,
// if enabled, go out raw with the timestamps in use once known. Throughput is
// one word per clock when not stalled, set by the single register-to-register
// update of the timestamp state. Words pass the input register, then the
// result register. Words that produce nothing still take their slot.
// Configuration writes are always ready and should only be issued while idle.
module pixel_packet_timestamp_tracker_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pptt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pptt_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input word channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pptt_pkg::WORD_W-1:0]      packet_word,
  // result word channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             result_kind,
  output logic [pptt_pkg::WORD_W-1:0]      raw_hit,
  output logic [pptt_pkg::TIME_W-1:0]      trigger_time,
  output logic [pptt_pkg::TIME_W-1:0]      global_time,
  output logic [pptt_pkg::LAYOUT_W-1:0]    chip_layout,
  output logic [pptt_pkg::COUNT_W-1:0]     chunk_packets
);
  import pptt_pkg::*;

  cfg_t              cfg;
  logic              advance;
  logic              word_valid;
  logic [WORD_W-1:0] word;
  result_t           result;

  // mode and extraction control
  pptt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, back-pressured only by a held result
  pptt_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packet_word (packet_word),
    .advance     (advance),
    .word_valid  (word_valid),
    .word        (word)
  );

  // classification, timestamp update and result register
  pptt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word_valid (word_valid),
    .word       (word),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  // result fields onto their own ports
  assign result_kind   = result.result_kind;
  assign raw_hit       = result.raw_hit;
  assign trigger_time  = result.trigger_time;
  assign global_time   = result.global_time;
  assign chip_layout   = result.chip_layout;
  assign chunk_packets = result.chunk_packets;

endmodule

// File: verif/pixel_packet_timestamp_tracker_unit_tb.sv
// testbench for pixel_packet_timestamp_tracker_unit: directed and random detector words,
// checked word by word against a timestamp tracker model kept in a scoreboard class
// depends on pptt_pkg and the rtl of the block only
`timescale 1ns / 1ps

module pixel_packet_timestamp_tracker_unit_tb;
  import pptt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
  localparam int SETTLE_CYCLES = 6;       // pipeline latency plus margin
  localparam int HOLD_CYCLES   = 300;     // long result back-pressure stretch
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_WORDS   = 300;

  // timestamp tracker model and queue of result words still due
  class tracker_scoreboard;
    logic               use_global;
    logic               extract_on;
    logic [TIME_W-1:0]  trig_clock;
    logic [TIME_W-1:0]  glob_clock;
    logic [HALF_W-1:0]  timer_low;
    logic [COUNT_W-1:0] packets_left;
    result_t            due_results[$];
    int                 error_count;

    function new();
      use_global   = 1'b1;
      extract_on   = 1'b1;
      trig_clock   = '0;
      glob_clock   = '0;
      timer_low    = '0;
      packets_left = '0;
      error_count  = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index,
                                 logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_USE_GLOBAL_TIME: use_global = data[0];
        CFG_EMIT_HITS:       extract_on = data[0];
        default: ;
      endcase
    endfunction

    function void push_result(logic kind, logic [WORD_W-1:0] raw,
                              logic [LAYOUT_W-1:0] layout, logic [COUNT_W-1:0] count);
      result_t r;
      r.result_kind   = kind;
      r.raw_hit       = raw;
      r.trigger_time  = trig_clock;
      r.global_time   = use_global ? glob_clock : '0;
      r.chip_layout   = layout;
      r.chunk_packets = count;
      due_results.push_back(r);
    endfunction

    // one accepted word: update the clocks, queue the result word if any
    function void note_word(logic [WORD_W-1:0] w);
      logic [HALF_W-1:0] t;
      logic [EXT_W-1:0]  hi;
      logic [TIME_W-1:0] v;
      if (w[7:0] == HDR_BYTE0 && w[15:8] == HDR_BYTE1 && w[23:16] == HDR_BYTE2) begin
        packets_left = w[63:51];
        push_result(KIND_HEADER, '0, w[39:32], packets_left);
        return;
      end
      if (packets_left == 0) return;
      packets_left = packets_left - 1'b1;
      if (w[63:56] == TOP_TRIGGER) begin
        t = w[43:12];
        if (use_global) begin
          hi = glob_clock[47:32];
          if (t < glob_clock[31:0]) hi = hi + 1'b1;
        end else begin
          hi = trig_clock[47:32];
          if (t < trig_clock[31:0] && (trig_clock[31:0] - t) > ROLL_GAP) hi = hi + 1'b1;
        end
        trig_clock = {hi, t};
      end else if (w[63:60] == NIB_GLOBAL) begin
        if (use_global) begin
          if (w[59:56] == SUB_TIMER_LOW) begin
            timer_low = w[47:16];
          end else if (w[59:56] == SUB_TIMER_HIGH) begin
            v = {w[31:16], timer_low};
            if (v != 0) glob_clock = v;
          end
        end
      end else if (w[63:60] == NIB_HIT) begin
        if (extract_on && trig_clock != 0 && (!use_global || glob_clock != 0))
          push_result(KIND_HIT, w, '0, '0);
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
    endtask

    task compare(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word with none due, kind %0d raw %h",
                         got.result_kind, got.raw_hit));
        return;
      end
      want = due_results.pop_front();
      compare("result_kind", WORD_W'(got.result_kind), WORD_W'(want.result_kind));
      compare("raw_hit", got.raw_hit, want.raw_hit);
      compare("trigger_time", WORD_W'(got.trigger_time), WORD_W'(want.trigger_time));
      compare("global_time", WORD_W'(got.global_time), WORD_W'(want.global_time));
      compare("chip_layout", WORD_W'(got.chip_layout), WORD_W'(want.chip_layout));
      compare("chunk_packets", WORD_W'(got.chunk_packets), WORD_W'(want.chunk_packets));
    endtask

    task check_drained();
      if (due_results.size() != 0)
        report($sformatf("%0d result words never arrived", due_results.size()));
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic [WORD_W-1:0]      packet_word = '0;
  logic                   out_stall   = 1'b0;

  // block outputs
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic                result_kind;
  logic [WORD_W-1:0]   raw_hit;
  logic [TIME_W-1:0]   trigger_time;
  logic [TIME_W-1:0]   global_time;
  logic [LAYOUT_W-1:0] chip_layout;
  logic [COUNT_W-1:0]  chunk_packets;

  // idling percentages of the current phase
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // long hold-off handshake between the stimulus and the receiver process
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  int cycle_count = 0;

  tracker_scoreboard tracker = new();

  // settings per random phase: global time mode and hit extraction
  bit phase_global [PHASE_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
  bit phase_hits   [PHASE_COUNT] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // directed words, run with the reset settings (global mode, hits on)
  logic [WORD_W-1:0] directed_words [22] = '{
    64'hB123_4567_89AB_CDEF,  // hit with no chunk open, ignored
    64'hFFFF_FFFF_FF58_5054,  // header, largest size and layout byte
    64'hBFFF_FFFF_FFFF_FFFF,  // hit before any timestamp, gated
    64'h4500_0000_0000_0000,  // timer high with zero result, not stored
    64'h6F00_0FFF_FFFF_F000,  // trigger, low half all ones
    64'hB000_0000_0000_0000,  // hit while global time still zero, gated
    64'h44FF_FFFF_FFFF_FFFF,  // timer low all ones
    64'h4500_0000_FFFF_0000,  // timer high, global time all ones
    64'h6F00_0000_0000_0000,  // trigger below global low half, upper half wraps
    64'hB000_0000_0000_0000,  // hit with trigger time back at zero, gated
    64'h6FFF_FFFF_FFFF_FFFF,  // trigger all ones
    64'hBFFF_FFFF_FFFF_FFFF,  // hit emitted, all ones
    64'hB000_0000_0000_0000,  // hit emitted, all zeros below the type
    64'h47AA_5555_AAAA_5555,  // global packet of another sub-type
    64'h0000_0000_0000_0000,  // unknown top byte
    64'hFFFF_FFFF_FFFF_FFFF,  // unknown top byte
    64'h0017_0000_0058_5054,  // header inside a chunk, reloads two packets
    64'hB555_AAAA_5555_AAAA,  // hit emitted
    64'h6F00_0123_4567_8000,  // trigger, closes the chunk
    64'hBAAA_5555_AAAA_5555,  // hit after the chunk ran out, ignored
    64'h0007_00A5_0058_5054,  // header announcing no packets
    64'hB000_0000_0000_0001   // ignored
  };

  pixel_packet_timestamp_tracker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packet_word  (packet_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .raw_hit      (raw_hit),
    .trigger_time (trigger_time),
    .global_time  (global_time),
    .chip_layout  (chip_layout),
    .chunk_packets(chunk_packets)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check accepted result words, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        tracker.check_result({result_kind, raw_hit, trigger_time, global_time,
                              chip_layout, chunk_packets});
      // a requested long hold-off, counted here
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // offer one word after an optional idle gap, return once it is accepted
  task automatic send_word(logic [WORD_W-1:0] word);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid    <= 1'b1;
    packet_word <= word;
    do @(posedge clk); while (in_stall);
    tracker.note_word(word);
  endtask

  // register write, only while the block is idle
  task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_register(index, data);
    @(posedge clk);
  endtask

  // stop offering until every due result word is back and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] header_word(logic [COUNT_W-1:0] count,
                                                    logic [LAYOUT_W-1:0] layout);
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    w[23:0]  = {HDR_BYTE2, HDR_BYTE1, HDR_BYTE0};
    w[39:32] = layout;
    w[63:51] = count;  // low three size bits stay random
    return w;
  endfunction

  // packet with random content, type weighted toward the timestamp path
  function automatic logic [WORD_W-1:0] random_packet();
    logic [WORD_W-1:0] w;
    int pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 22)      w[63:56] = TOP_TRIGGER;
    else if (pick < 37) w[63:56] = {NIB_GLOBAL, SUB_TIMER_LOW};
    else if (pick < 52) w[63:56] = {NIB_GLOBAL, SUB_TIMER_HIGH};
    else if (pick < 85) w[63:60] = NIB_HIT;
    else if (pick < 90) w[63:60] = NIB_GLOBAL;  // any sub-type
    return w;  // else whatever top byte came up
  endfunction

  // one chunk: header plus its packets, sometimes cut short; now and then a stray word
  task automatic send_chunk(inout int counted);
    int n;
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_word({$urandom, $urandom});  // noise, not counted
      return;
    end
    if (pick < 10)      n = 0;
    else if (pick < 13) n = $urandom_range(300, 25);
    else                n = $urandom_range(24, 1);
    len = n;
    if (n > 1 && $urandom_range(99) < 12) len = $urandom_range(n - 1, 0);  // broken chunk
    send_word(header_word(n[COUNT_W-1:0], LAYOUT_W'($urandom_range(255))));
    counted++;
    repeat (len) begin
      send_word(random_packet());
      counted++;
    end
  endtask

  task automatic run_phase(int words);
    int counted;
    bit held;
    bit paused;
    counted = 0;
    held    = 1'b0;
    paused  = 1'b0;
    while (counted < words) begin
      // long back-pressure while words keep coming, so the input stalls
      if (!held && counted >= 40) begin
        hold_requests++;
        held = 1'b1;
      end
      // one pause mid-phase until every result word is back
      if (!paused && counted >= words / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_chunk(counted);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words with no idling
    foreach (directed_words[i]) send_word(directed_words[i]);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_register(CFG_USE_GLOBAL_TIME, phase_global[p]);
      write_register(CFG_EMIT_HITS, phase_hits[p]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 74; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 74; end
        default: begin in_idle_pct = 29; out_stall_pct = 29; end
      endcase
      run_phase(PHASE_WORDS);
      wait_drained();
    end

    tracker.check_drained();
    if (tracker.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
